[rtl/core/crc_framed_packet_builder_assert.svh]
// Assertion macros for the framed packet builder.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef CRC_FRAMED_PACKET_BUILDER_ASSERT_SVH
`define CRC_FRAMED_PACKET_BUILDER_ASSERT_SVH

// Same-cycle implication.
`define CFPB_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CFPB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/cfpb_pkg.sv]
// Shared types and constants of the framed packet builder.
// No dependencies; used by the engine, the serializer and the top level.
package cfpb_pkg;

  localparam int MaxResults = 9;
  localparam int CountW     = 4;

  typedef enum logic [1:0] {
    CmdBegin    = 2'd0,
    CmdPayload  = 2'd1,
    CmdSeqReset = 2'd2,
    CmdUnused   = 2'd3
  } cmd_e;

  // Byte group produced by one request; byte 0 goes out first.
  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [CountW-1:0]          count;
    logic                       close;
  } bundle_t;

endpackage

[rtl/core/cfpb_frame_engine.sv]
// Frame state (sequence, CRC, remaining count) and the byte-parallel CRC.
// Depends on cfpb_pkg; builds one byte group per consumed request.
module cfpb_frame_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  cfpb_pkg::cmd_e     cmd_i,
  input  logic [7:0]         frame_type_i,
  input  logic [15:0]        payload_length_i,
  input  logic [7:0]         payload_byte_i,
  output cfpb_pkg::bundle_t  bundle_o
);

  localparam logic [7:0]  StartCode = 8'h24;
  localparam logic [7:0]  EndCode   = 8'h0D;
  localparam logic [15:0] CrcSeed   = 16'hFFFF;
  localparam logic [15:0] CrcPoly   = 16'h1021;

  // Augmented CRC: shift message bits in at the bottom, MSB first.
  function automatic logic [15:0] crc_shift_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[15];
      c  = {c[14:0], b[7-i]};
      if (fb) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

  logic [15:0] seq_q, seq_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] rem_q, rem_d;
  logic        open_q, open_d;

  logic [5:0][7:0]  hdr;
  logic [6:0][15:0] crc_h;
  logic [15:0]      crc_pay;
  logic [15:0]      rem_dec;
  logic [15:0]      crc_pre;
  logic [15:0]      crc_z1;
  logic [15:0]      crc_fin;

  assign hdr = {payload_length_i[15:8], payload_length_i[7:0], frame_type_i,
                seq_q[15:8], seq_q[7:0], StartCode};

  always_comb begin
    crc_h[0] = CrcSeed;
    for (int i = 0; i < 6; i++) begin
      crc_h[i+1] = crc_shift_byte(crc_h[i], hdr[i]);
    end
  end

  assign crc_pay = crc_shift_byte(crc_q, payload_byte_i);
  assign rem_dec = rem_q - 16'd1;
  assign crc_pre = (cmd_i == cfpb_pkg::CmdBegin) ? crc_h[6] : crc_pay;
  assign crc_z1  = crc_shift_byte(crc_pre, 8'h00);
  assign crc_fin = crc_shift_byte(crc_z1, 8'h00);

  always_comb begin
    seq_d          = seq_q;
    crc_d          = crc_q;
    rem_d          = rem_q;
    open_d         = open_q;
    bundle_o       = '0;
    case (cmd_i)
      cfpb_pkg::CmdBegin: begin
        seq_d = seq_q + 16'd1;
        for (int i = 0; i < 6; i++) begin
          bundle_o.bytes[i] = hdr[i];
        end
        if (payload_length_i == 16'd0) begin
          bundle_o.bytes[6] = crc_fin[7:0];
          bundle_o.bytes[7] = crc_fin[15:8];
          bundle_o.bytes[8] = EndCode;
          bundle_o.count    = cfpb_pkg::CountW'(9);
          bundle_o.close    = 1'b1;
          crc_d             = CrcSeed;
          rem_d             = 16'd0;
          open_d            = 1'b0;
        end else begin
          bundle_o.count = cfpb_pkg::CountW'(6);
          crc_d          = crc_h[6];
          rem_d          = payload_length_i;
          open_d         = 1'b1;
        end
      end
      cfpb_pkg::CmdPayload: begin
        if (open_q) begin
          bundle_o.bytes[0] = payload_byte_i;
          if (rem_dec == 16'd0) begin
            bundle_o.bytes[1] = crc_fin[7:0];
            bundle_o.bytes[2] = crc_fin[15:8];
            bundle_o.bytes[3] = EndCode;
            bundle_o.count    = cfpb_pkg::CountW'(4);
            bundle_o.close    = 1'b1;
            crc_d             = CrcSeed;
            rem_d             = 16'd0;
            open_d            = 1'b0;
          end else begin
            bundle_o.count = cfpb_pkg::CountW'(1);
            crc_d          = crc_pay;
            rem_d          = rem_dec;
          end
        end
      end
      cfpb_pkg::CmdSeqReset: begin
        seq_d = 16'd0;
      end
      default: begin
        // unused command: no change
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q  <= 16'd0;
      crc_q  <= CrcSeed;
      rem_q  <= 16'd0;
      open_q <= 1'b0;
    end else if (step_i) begin
      seq_q  <= seq_d;
      crc_q  <= crc_d;
      rem_q  <= rem_d;
      open_q <= open_d;
    end
  end

endmodule

[rtl/core/cfpb_byte_serializer.sv]
// Result register and byte shifter that drives the output stream.
// Depends on cfpb_pkg and crc_framed_packet_builder_assert.svh.
`include "crc_framed_packet_builder_assert.svh"

module cfpb_byte_serializer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  cfpb_pkg::bundle_t bundle_i,
  output logic              free_o,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [7:0]        m_axis_tdata_o,   // [7:0] out_byte
  output logic              m_axis_tuser_o,   // [0] frame_end
  output logic              m_axis_tlast_o    // run_last
);

  localparam int N = cfpb_pkg::MaxResults;

  logic [N-1:0][7:0]           bytes_q, bytes_d;
  logic [cfpb_pkg::CountW-1:0] count_q, count_d;
  logic                        close_q, close_d;
  logic                        emit;
  logic                        last;

  assign last            = (count_q == cfpb_pkg::CountW'(1));
  assign emit            = m_axis_tvalid_o && m_axis_tready_i;
  assign free_o          = (count_q == '0) || (emit && last);
  assign m_axis_tvalid_o = (count_q != '0);
  assign m_axis_tdata_o  = bytes_q[0];
  assign m_axis_tlast_o  = last;
  assign m_axis_tuser_o  = close_q && last;

  always_comb begin
    bytes_d = bytes_q;
    count_d = count_q;
    close_d = close_q;
    if (load_i) begin
      bytes_d = bundle_i.bytes;
      count_d = bundle_i.count;
      close_d = bundle_i.close;
    end else if (emit) begin
      // advance to the next byte of the group
      bytes_d = {8'h00, bytes_q[N-1:1]};
      count_d = count_q - cfpb_pkg::CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      close_q <= 1'b0;
    end else begin
      count_q <= count_d;
      close_q <= close_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
  end

  `CFPB_ASSERT_IMPL(a_load_when_free, load_i, free_o, "byte group loaded over pending bytes")
  `CFPB_ASSERT_IMPL(a_load_count, load_i,
                    bundle_i.count != '0 && bundle_i.count <= cfpb_pkg::CountW'(N),
                    "byte group with bad count")
  `CFPB_ASSERT_NEXT(a_count_step, emit && !last && !load_i,
                    m_axis_tvalid_o && count_q == $past(count_q) - cfpb_pkg::CountW'(1),
                    "byte count did not step down")
  `CFPB_ASSERT_IMPL(a_end_is_last, m_axis_tuser_o, m_axis_tlast_o,
                    "frame end flagged before the last byte of a group")

endmodule

[rtl/core/crc_framed_packet_builder.sv]
// Framed packet builder: input request register, frame engine, byte serializer.
// The first byte of a request is offered from the serializer's result register, after the
// request has passed the input request register and been loaded by the frame engine.
// Throughput: one request per cycle while each request yields at most one byte and the sink
// takes each byte; a request yielding N bytes (N up to 9) holds back later byte-yielding requests.
// Reset: sequence number 0, CRC at seed 0xFFFF, no frame open, both registers empty.
// Depends on cfpb_pkg, cfpb_frame_engine and cfpb_byte_serializer.
module crc_framed_packet_builder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [7:0] frame_type, [23:8] payload_length,
                                        // [31:24] payload_byte
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] cmd
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] out_byte
  output logic        m_axis_tuser_o,   // [0] frame_end
  output logic        m_axis_tlast_o    // run_last
);

  logic              in_valid_q;
  logic [31:0]       in_data_q;
  logic [1:0]        in_cmd_q;
  logic              free;
  logic              consume;
  logic              load;
  cfpb_pkg::bundle_t bundle;

  // Requests that yield no bytes pass without waiting on the serializer.
  assign consume         = in_valid_q && (free || (bundle.count == '0));
  assign load            = consume && (bundle.count != '0);
  assign s_axis_tready_o = !in_valid_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_data_q <= s_axis_tdata_i;
      in_cmd_q  <= s_axis_tuser_i;
    end
  end

  cfpb_frame_engine u_engine (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (consume),
    .cmd_i            (cfpb_pkg::cmd_e'(in_cmd_q)),
    .frame_type_i     (in_data_q[7:0]),
    .payload_length_i (in_data_q[23:8]),
    .payload_byte_i   (in_data_q[31:24]),
    .bundle_o         (bundle)
  );

  cfpb_byte_serializer u_serializer (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (load),
    .bundle_i        (bundle),
    .free_o          (free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

[verif/cfpb_frame_checker.sv]
// Checker for the framed packet builder: predicts the byte stream of every accepted request
// and compares each accepted output byte with the oldest expected one.
// Depends on cfpb_pkg for the command codes and the result count.
module cfpb_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [31:0] in_data_i,       // [7:0] frame_type, [23:8] payload_length,
                                       // [31:24] payload_byte
  input  logic [1:0]  in_user_i,       // [1:0] cmd
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  out_data_i,      // [7:0] out_byte
  input  logic        out_frame_end_i,
  input  logic        out_last_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          bytes_checked_o,
  output int          frames_closed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0]  StartByte  = 8'h24;
  localparam logic [7:0]  EndByte    = 8'h0D;
  localparam logic [15:0] CrcSeed    = 16'hFFFF;
  localparam logic [15:0] CrcPoly    = 16'h1021;
  localparam int          MaxReports = 10;

  typedef struct packed {
    logic [7:0] value;
    logic       frame_end;
    logic       run_last;
  } framed_byte_t;

  framed_byte_t expected_bytes[$];

  logic [15:0] seq_num;
  logic [15:0] crc_acc;
  logic [15:0] bytes_left;
  logic        in_frame;

  logic [7:0]  burst_val[cfpb_pkg::MaxResults];
  logic        burst_end[cfpb_pkg::MaxResults];
  int          burst_n;

  int mismatches    = 0;
  int bytes_checked = 0;
  int frames_closed = 0;

  // Augmented form: the byte is shifted in below the register, MSB first.
  function automatic logic [15:0] crc_shift(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15];
      c  = {c[14:0], b[i]};
      if (fb) c = c ^ CrcPoly;
    end
    return c;
  endfunction

  task automatic add_byte(input logic [7:0] v, input logic fe);
    burst_val[burst_n] = v;
    burst_end[burst_n] = fe;
    burst_n++;
  endtask

  task automatic add_framed(input logic [7:0] v);
    crc_acc = crc_shift(crc_acc, v);
    add_byte(v, 1'b0);
  endtask

  task automatic add_trailer();
    logic [15:0] c;
    c = crc_shift(crc_shift(crc_acc, 8'h00), 8'h00);
    add_byte(c[7:0], 1'b0);
    add_byte(c[15:8], 1'b0);
    add_byte(EndByte, 1'b1);
    in_frame   = 1'b0;
    bytes_left = '0;
    crc_acc    = CrcSeed;
    frames_closed++;
  endtask

  task automatic predict_frame_bytes(input cfpb_pkg::cmd_e cmd, input logic [7:0] ftype,
                                     input logic [15:0] len, input logic [7:0] data);
    burst_n = 0;
    case (cmd)
      cfpb_pkg::CmdBegin: begin
        crc_acc = CrcSeed;
        add_framed(StartByte);
        add_framed(seq_num[7:0]);
        add_framed(seq_num[15:8]);
        add_framed(ftype);
        add_framed(len[7:0]);
        add_framed(len[15:8]);
        seq_num    = seq_num + 16'd1;
        in_frame   = 1'b1;
        bytes_left = len;
        if (len == 16'd0) add_trailer();
      end
      cfpb_pkg::CmdPayload: begin
        // drop bytes that arrive outside a frame
        if (in_frame) begin
          add_framed(data);
          bytes_left = bytes_left - 16'd1;
          if (bytes_left == 16'd0) add_trailer();
        end
      end
      cfpb_pkg::CmdSeqReset: seq_num = '0;
      default: ;
    endcase
    for (int i = 0; i < burst_n; i++)
      expected_bytes.push_back('{value: burst_val[i], frame_end: burst_end[i],
                                 run_last: (i == burst_n - 1)});
  endtask

  task automatic check_byte(input framed_byte_t got);
    framed_byte_t want;
    bytes_checked++;
    if (expected_bytes.size() == 0) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("[%0t] unexpected byte %02h frame_end=%0b run_last=%0b", $time,
                 got.value, got.frame_end, got.run_last);
    end else begin
      want = expected_bytes.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("[%0t] byte mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b", $time,
                   want.value, want.frame_end, want.run_last,
                   got.value, got.frame_end, got.run_last);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_num    = '0;
      crc_acc    = CrcSeed;
      bytes_left = '0;
      in_frame   = 1'b0;
      expected_bytes.delete();
      pending_o  <= 0;
    end else begin
      if (in_valid_i && in_ready_i)
        predict_frame_bytes(cfpb_pkg::cmd_e'(in_user_i), in_data_i[7:0], in_data_i[23:8],
                            in_data_i[31:24]);
      if (out_valid_i && out_ready_i)
        check_byte('{value: out_data_i, frame_end: out_frame_end_i, run_last: out_last_i});
      pending_o <= expected_bytes.size();
    end
    fail_count_o    <= mismatches;
    bytes_checked_o <= bytes_checked;
    frames_closed_o <= frames_closed;
  end

endmodule

[verif/tb_crc_framed_packet_builder.sv]
// Testbench top for crc_framed_packet_builder: clock, reset, request and sink drivers,
// and the verdict. Depends on cfpb_pkg, the block itself and cfpb_frame_checker.
module tb_crc_framed_packet_builder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkPeriod      = 8;
  localparam int ResetCycles    = 7;
  localparam int SinkHoldCycles = 300;
  localparam int DrainCycles    = 20;
  localparam int CycleLimit     = 100000;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [31:0] s_data  = '0;
  logic [1:0]  s_user  = cfpb_pkg::CmdUnused;
  logic        m_ready = 1'b0;

  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [7:0]  m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        m_axis_tlast_o;

  int fail_count;
  int pending;
  int bytes_checked;
  int frames_closed;
  int items_sent  = 0;
  int cycle_count = 0;

  logic src_idle_en   = 1'b1;
  logic sink_idle_en  = 1'b1;
  logic sink_hold_req = 1'b0;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  crc_framed_packet_builder u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  cfpb_frame_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_valid),
    .in_ready_i      (s_axis_tready_o),
    .in_data_i       (s_data),
    .in_user_i       (s_user),
    .out_valid_i     (m_axis_tvalid_o),
    .out_ready_i     (m_ready),
    .out_data_i      (m_axis_tdata_o),
    .out_frame_end_i (m_axis_tuser_o),
    .out_last_i      (m_axis_tlast_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .bytes_checked_o (bytes_checked),
    .frames_closed_o (frames_closed)
  );

  // Offer one request and hold it until the block takes it.
  task automatic send_item(input cfpb_pkg::cmd_e cmd, input logic [7:0] ftype,
                           input logic [15:0] len, input logic [7:0] data);
    if (src_idle_en && $urandom_range(99) < 12) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {data, len, ftype};
    s_user  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Mostly complete frames with random content; some truncated frames and noise.
  task automatic random_frames(input int n);
    int stop_at;
    int pick;
    int len;
    int cut;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        case ($urandom_range(2))
          0: send_item(cfpb_pkg::CmdSeqReset, 8'($urandom), 16'($urandom), 8'($urandom));
          1: send_item(cfpb_pkg::CmdUnused, 8'($urandom), 16'($urandom), 8'($urandom));
          default: send_item(cfpb_pkg::CmdPayload, 8'($urandom), 16'($urandom),
                             8'($urandom));
        endcase
      end else begin
        len = (pick < 15) ? $urandom_range(20, 40) : $urandom_range(0, 6);
        // truncate now and then so the next begin abandons the frame
        cut = (pick >= 90) ? $urandom_range(0, len) : len;
        send_item(cfpb_pkg::CmdBegin, 8'($urandom), 16'(len), 8'($urandom));
        repeat (cut) send_item(cfpb_pkg::CmdPayload, 8'($urandom), 16'($urandom),
                               8'($urandom));
      end
    end
  endtask

  initial begin : sink_driver
    int  hold_left;
    bit  hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (sink_hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = SinkHoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= !(sink_idle_en && $urandom_range(99) < 12);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle noise, empty frame, one-byte frame
    send_item(cfpb_pkg::CmdSeqReset, 8'h00, 16'h0000, 8'h00);
    send_item(cfpb_pkg::CmdPayload,  8'h00, 16'h0000, 8'hFF);
    send_item(cfpb_pkg::CmdUnused,   8'hFF, 16'hFFFF, 8'hFF);
    send_item(cfpb_pkg::CmdBegin,    8'h00, 16'h0000, 8'h00);
    send_item(cfpb_pkg::CmdBegin,    8'hFF, 16'h0001, 8'hFF);
    send_item(cfpb_pkg::CmdPayload,  8'hFF, 16'hFFFF, 8'h00);
    // longest frame, sequence reset inside it, then abandon it
    send_item(cfpb_pkg::CmdBegin,    8'hA5, 16'hFFFF, 8'h00);
    send_item(cfpb_pkg::CmdPayload,  8'h00, 16'h0000, 8'hFF);
    send_item(cfpb_pkg::CmdSeqReset, 8'h00, 16'h0000, 8'h00);
    send_item(cfpb_pkg::CmdPayload,  8'h00, 16'h0000, 8'h5A);
    send_item(cfpb_pkg::CmdUnused,   8'h00, 16'h0000, 8'h00);
    send_item(cfpb_pkg::CmdBegin,    8'h3C, 16'h0002, 8'h00);
    send_item(cfpb_pkg::CmdPayload,  8'h00, 16'h0000, 8'h80);
    send_item(cfpb_pkg::CmdPayload,  8'h00, 16'h0000, 8'h7F);
    send_item(cfpb_pkg::CmdBegin,    8'h01, 16'h0003, 8'h00);
    send_item(cfpb_pkg::CmdPayload,  8'h00, 16'h0000, 8'h01);
    send_item(cfpb_pkg::CmdPayload,  8'h00, 16'h0000, 8'h02);
    send_item(cfpb_pkg::CmdPayload,  8'h00, 16'h0000, 8'h04);

    random_frames(60);
    // hold the sink while requests keep coming, so the block backs up
    src_idle_en = 1'b0;
    sink_hold_req <= 1'b1;
    random_frames(25);
    sink_idle_en <= 1'b0;
    random_frames(25);
    src_idle_en = 1'b1;
    sink_idle_en <= 1'b1;
    random_frames(50);
    s_valid <= 1'b0;

    // let the last accepted request reach the predictor before waiting on it
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run covered %0d requests and %0d output bytes in %0d closed frames,",
             items_sent, bytes_checked, frames_closed);
    $display("with stray, abandoned and empty frames and a %0d-cycle sink stall.",
             SinkHoldCycles);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
